@@ hw/rtl/bclp_pkg.sv @@
`timescale 1ns / 1ps
package bclp_pkg;
  localparam int unsigned NumSets    = 256;
  localparam int unsigned NumWays    = 4;
  localparam int unsigned BlockWords = 8;
  localparam int unsigned AddrBits   = 32;
  localparam int unsigned OffW  = $clog2(BlockWords);
  localparam int unsigned SetW  = $clog2(NumSets);
  localparam int unsigned WayW  = $clog2(NumWays);
  localparam int unsigned TagW  = AddrBits - OffW - SetW;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegWriteAllocate = 1'b0,
    RegPrefetchEnable = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdStore = 1'b1
  } cmd_e;

  typedef struct packed {
    logic           cmd;
    logic [AddrBits-1:0] address;
  } req_t;

  typedef struct packed {
    logic hit;
    logic allocated;
    logic prefetch_filled;
  } rsp_t;

  typedef logic [WayW-1:0] rank_t;

  typedef struct packed {
    logic  [NumWays-1:0]           valid;
    logic  [NumWays-1:0][WayW-1:0] rank;
    logic  [NumWays-1:0][TagW-1:0] tag;
  } set_t;
endpackage

@@ hw/rtl/bclp_if.sv @@
`timescale 1ns / 1ps
interface bclp_req_if;
  logic valid;
  logic ready;
  bclp_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bclp_rsp_if;
  logic valid;
  logic ready;
  bclp_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/block_cache_lru_prefetch.sv @@
`timescale 1ns / 1ps
// Tag side of a 4-way, 256-set LRU cache with 8-word blocks and optional
// next-block prefetch on load misses. Each set (valid bits, recency ranks and
// tags) is one word of a synchronous set memory that is read and later
// written back. An item without prefetch passes through the read and write
// states, and its result is registered when its set is written back. A load
// miss with prefetch enabled adds a prefetch read and a second write, since
// the prefetch needs a second read-modify-write of the memory. One item is in
// work at a time; the finished result sits in an output register while the
// next item is accepted, and a result that is not taken holds the final
// write-back of the next item until the register frees. After reset, a
// clearing pass over all 256 sets zeroes the valid bits of every set before
// the first item is taken.
module block_cache_lru_prefetch (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [bclp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bclp_pkg::CfgDataW-1:0] cfg_data_i,
  bclp_req_if.sink   req,
  bclp_rsp_if.source rsp
);
  import bclp_pkg::*;

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StRead  = 5'b00100,
    StWrite = 5'b01000,
    StPfRd  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic wa_q, pe_q;
  logic [SetW-1:0] clr_q;
  logic cmd_q;
  logic [AddrBits-1:0] addr_q;
  logic pf_q;
  logic hit_q;
  logic alloc_q;
  logic ovalid_q;
  rsp_t odata_q;

  set_t mem [NumSets];
  set_t rd_q;

  logic [AddrBits-1:0] cur_addr;
  logic [SetW-1:0] cur_set, rd_set;
  logic [TagW-1:0] cur_tag;
  assign cur_addr = addr_q;
  assign cur_set  = cur_addr[OffW +: SetW];
  assign cur_tag  = cur_addr[AddrBits-1 -: TagW];

  logic mem_we;
  logic [SetW-1:0] mem_wa;
  set_t mem_wd;

  // combinational set update
  logic found, any_inv;
  logic [WayW-1:0] hit_w, inv_w, lru_w, tgt_w;
  logic do_fill, do_touch;
  rank_t old_r;
  logic old_v;
  set_t upd;

  always_comb begin
    found = 1'b0; hit_w = '0;
    any_inv = 1'b0; inv_w = '0; lru_w = '0;
    for (int w = NumWays-1; w >= 0; w--) begin
      if (rd_q.valid[w] && rd_q.tag[w] == cur_tag) begin
        found = 1'b1; hit_w = WayW'(w);
      end
      if (!rd_q.valid[w]) begin
        any_inv = 1'b1; inv_w = WayW'(w);
      end
    end
    for (int w = 0; w < NumWays; w++) begin
      if (rd_q.rank[w] == rank_t'(NumWays-1)) lru_w = WayW'(w);
    end
    if (pf_q) do_fill = !found;
    else do_fill = !found && (cmd_q == CmdLoad || wa_q);
    do_touch = found || do_fill;
    tgt_w = found ? hit_w : (any_inv ? inv_w : lru_w);
    old_v = rd_q.valid[tgt_w];
    old_r = rd_q.rank[tgt_w];
    upd = rd_q;
    if (do_touch) begin
      for (int v = 0; v < NumWays; v++) begin
        if (WayW'(v) != tgt_w && rd_q.valid[v] && (!old_v || rd_q.rank[v] < old_r))
          upd.rank[v] = rd_q.rank[v] + rank_t'(1);
      end
      upd.rank[tgt_w] = '0;
      upd.valid[tgt_w] = 1'b1;
      if (do_fill) upd.tag[tgt_w] = cur_tag;
    end
  end

  logic [AddrBits-1:0] next_addr;
  assign next_addr = addr_q + AddrBits'(BlockWords);

  logic out_free;
  assign out_free  = !ovalid_q || rsp.ready;
  assign req.ready = (state_q == StIdle);
  assign rd_set = (state_q == StIdle) ? req.data.address[OffW +: SetW] : cur_set;

  always_comb begin
    state_d = state_q;
    mem_we = 1'b0; mem_wa = cur_set; mem_wd = upd;
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1; mem_wa = clr_q; mem_wd = '0;
        if (clr_q == SetW'(NumSets-1)) state_d = StIdle;
      end
      StIdle: if (req.valid) state_d = StRead;
      StRead: state_d = StWrite;
      StPfRd: state_d = StWrite;
      StWrite: begin
        if (out_free || (!pf_q && !found && cmd_q == CmdLoad && pe_q)) begin
          mem_we = 1'b1;
          if (!pf_q && !found && cmd_q == CmdLoad && pe_q) state_d = StPfRd;
          else state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[rd_set];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      wa_q <= 1'b1;
      pe_q <= 1'b0;
      ovalid_q <= 1'b0;
      pf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + SetW'(1);
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          RegWriteAllocate:  wa_q <= cfg_data_i[0];
          RegPrefetchEnable: pe_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == StIdle) pf_q <= 1'b0;
      else if (state_q == StWrite && mem_we && state_d == StPfRd) pf_q <= 1'b1;
      if (state_q == StWrite && mem_we && state_d != StPfRd) ovalid_q <= 1'b1;
      else if (rsp.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req.valid) begin
      cmd_q <= req.data.cmd;
      addr_q <= req.data.address;
    end
    if (state_q == StWrite && mem_we) begin
      if (state_d == StPfRd) begin
        hit_q <= 1'b0;
        alloc_q <= 1'b1;
        addr_q <= next_addr;
      end else if (pf_q) begin
        odata_q <= '{hit: hit_q, allocated: alloc_q, prefetch_filled: !found};
      end else begin
        odata_q <= '{hit: found, allocated: do_fill, prefetch_filled: 1'b0};
      end
    end
  end

  assign rsp.valid = ovalid_q;
  assign rsp.data  = odata_q;
endmodule

@@ hw/rtl/bclp_checker.sv @@
`timescale 1ns / 1ps
module bclp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input bclp_pkg::rsp_t rsp_data
);
  import bclp_pkg::*;

  a_hit_no_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(rsp_data.hit && (rsp_data.allocated || rsp_data.prefetch_filled)))
    else $error("hit with fill");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("second item too soon");

  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("result too early");
endmodule

bind block_cache_lru_prefetch bclp_checker u_bclp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

@@ dv/bclp_test_if.sv @@
`timescale 1ns / 1ps

@@ dv/block_cache_lru_prefetch_test.sv @@
`timescale 1ns / 1ps
module block_cache_lru_prefetch_test;
  import bclp_pkg::*;

  localparam int unsigned MaxCycles = 400000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bclp_req_if req ();
  bclp_rsp_if rsp ();

  block_cache_lru_prefetch dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req.sink),
    .rsp        (rsp.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // cache shadow
  logic [TagW-1:0] tag_q [NumSets][NumWays];
  bit valid_q [NumSets][NumWays];
  int unsigned rank_q [NumSets][NumWays];
  bit wr_alloc;
  bit pf_en;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit hold_send;
  int errors;
  int unsigned cycles;

  function automatic void touch(int unsigned s, int unsigned w);
    int unsigned r;
    r = valid_q[s][w] ? rank_q[s][w] : NumWays;
    for (int unsigned v = 0; v < NumWays; v++) begin
      if (v != w && valid_q[s][v] && rank_q[s][v] < r) rank_q[s][v]++;
    end
    rank_q[s][w] = 0;
    valid_q[s][w] = 1'b1;
  endfunction

  function automatic bit probe(logic [AddrBits-1:0] a);
    int unsigned s;
    s = 32'(a[OffW +: SetW]);
    for (int unsigned w = 0; w < NumWays; w++) begin
      if (valid_q[s][w] && tag_q[s][w] == a[AddrBits-1 -: TagW]) begin
        touch(s, w);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void install(logic [AddrBits-1:0] a);
    int unsigned s;
    int unsigned victim;
    bit found;
    s = 32'(a[OffW +: SetW]);
    victim = 0;
    found = 1'b0;
    for (int unsigned w = 0; w < NumWays; w++) begin
      if (!found && !valid_q[s][w]) begin
        victim = w;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int unsigned w = 0; w < NumWays; w++) begin
        if (rank_q[s][w] == NumWays - 1) victim = w;
      end
    end
    tag_q[s][victim] = a[AddrBits-1 -: TagW];
    touch(s, victim);
  endfunction

  function automatic rsp_t predict_access(req_t r);
    rsp_t o;
    logic [AddrBits-1:0] nxt;
    o = '0;
    o.hit = probe(r.address);
    if (!o.hit) begin
      if (r.cmd == CmdLoad || wr_alloc) begin
        install(r.address);
        o.allocated = 1'b1;
      end
      if (r.cmd == CmdLoad && pf_en) begin
        nxt = r.address + AddrBits'(BlockWords);
        if (!probe(nxt)) begin
          install(nxt);
          o.prefetch_filled = 1'b1;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.data <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(predict_access(req.data));
        void'(pending_reqs.pop_front());
      end
      if (req.valid && !req.ready) begin
        // hold
      end else if (pending_reqs.size() > (req.valid && req.ready ? 0 : 0) && !hold_send
                   && $urandom_range(99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        req.data <= pending_reqs[0];
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result item %b", rsp.data);
          errors++;
        end else begin
          if (rsp.data.hit !== expected_rsps[0].hit) begin
            $error("hit exp %b got %b", expected_rsps[0].hit, rsp.data.hit);
            errors++;
          end
          if (rsp.data.allocated !== expected_rsps[0].allocated) begin
            $error("allocated exp %b got %b", expected_rsps[0].allocated,
                   rsp.data.allocated);
            errors++;
          end
          if (rsp.data.prefetch_filled !== expected_rsps[0].prefetch_filled) begin
            $error("prefetch_filled exp %b got %b", expected_rsps[0].prefetch_filled,
                   rsp.data.prefetch_filled);
            errors++;
          end
          void'(expected_rsps.pop_front());
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWriteAllocate) wr_alloc = v;
    else pf_en = v;
  endtask

  function automatic void queue_item(logic c, logic [AddrBits-1:0] a);
    req_t r;
    r.cmd = c;
    r.address = a;
    pending_reqs.push_back(r);
  endfunction

  // hot set of block addresses so sets fill and evict
  function automatic logic [AddrBits-1:0] hot_addr();
    logic [AddrBits-1:0] a;
    a = $urandom();
    a[OffW +: SetW] = SetW'($urandom_range(3));
    a[AddrBits-1 -: TagW] = TagW'($urandom_range(7)) ^ {TagW{1'($urandom_range(1))}};
    return a;
  endfunction

  function automatic void queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) queue_item(1'($urandom_range(1)), hot_addr());
      else queue_item(1'($urandom_range(1)), $urandom());
    end
  endfunction

  initial begin
    errors = 0;
    cycles = 0;
    hold_send = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 71;
    wr_alloc = 1'b1;
    pf_en = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    foreach (valid_q[s, w]) begin
      valid_q[s][w] = 1'b0;
      rank_q[s][w] = 0;
      tag_q[s][w] = '0;
    end
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fill one set past its ways, store misses, extremes, wrap
    for (int t = 0; t < 6; t++) queue_item(CmdLoad, {TagW'(t), SetW'(5), OffW'(t)});
    queue_item(CmdLoad, {TagW'(2), SetW'(5), OffW'(7)});
    queue_item(CmdStore, 32'hFFFF_FFFF);
    queue_item(CmdStore, 32'h0);
    queue_item(CmdLoad, 32'h0);
    drain();
    write_reg(RegWriteAllocate, 1'b0);
    write_reg(RegPrefetchEnable, 1'b1);
    queue_item(CmdStore, 32'hAAAA_5555);
    queue_item(CmdStore, 32'hAAAA_5555);
    queue_item(CmdLoad, 32'hFFFF_FFF8);
    queue_item(CmdLoad, 32'h0000_0000);
    queue_item(CmdLoad, 32'h5555_AAA0);
    queue_item(CmdLoad, 32'h5555_AAA8);
    queue_item(CmdLoad, 32'h1234_5670);
    drain();
    write_reg(RegWriteAllocate, 1'b1);
    queue_item(CmdStore, 32'h7777_0000);
    queue_item(CmdStore, 32'h7777_0000);
    queue_random(500);
    drain();

    send_idle_pct = 71;
    recv_idle_pct = 10;
    write_reg(RegPrefetchEnable, 1'b0);
    write_reg(RegWriteAllocate, 1'b0);
    queue_random(550);
    wait (pending_reqs.size() < 300);
    hold_send = 1'b1;
    @(posedge clk_i);
    while (expected_rsps.size() != 0 || req.valid) @(posedge clk_i);
    hold_send = 1'b0;
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegWriteAllocate, 1'b1);
    write_reg(RegPrefetchEnable, 1'b1);
    queue_random(550);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/bclp_pkg.sv
hw/rtl/bclp_if.sv
hw/rtl/block_cache_lru_prefetch.sv
hw/rtl/bclp_checker.sv
dv/bclp_test_if.sv
dv/block_cache_lru_prefetch_test.sv
